FILE: src/tal_pkg.sv
// Shared constants, codes and helpers for the binary-lifting ancestor engine.
// Used by tree_ancestor_binary_lifting_core and its checker; depends on nothing.
package tal_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int LIFT_LEVELS = 10;

    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = NODE_W + 1;
    localparam int DEPTH_W = 10;
    localparam int DPT_W   = DEPTH_W + 1;
    localparam int LEVEL_W = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
    localparam int LVLC_W  = $clog2(LIFT_LEVELS + 1);
    localparam int JT_DEPTH = LIFT_LEVELS * MAX_NODES;
    localparam int JT_AW    = $clog2(JT_DEPTH);

    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int S_TDATA_W = ((2 * NODE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((NODE_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0]   MAX_COUNT  = CNT_W'(MAX_NODES);
    localparam logic [CNT_W-1:0]   COUNT_RST  = CNT_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX  = {DEPTH_W{1'b1}};
    localparam logic [LVLC_W-1:0]  LEVEL_TOP  = LVLC_W'(LIFT_LEVELS);

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ANSWER = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REJECT = 2'd2;

    // Entry (level, node) of the jump table sits at level * MAX_NODES + node.
    function automatic logic [JT_AW-1:0] jt_addr(input logic [LEVEL_W-1:0] lvl,
                                                input logic [NODE_W-1:0] node);
        jt_addr = JT_AW'({lvl, node});
    endfunction

endpackage

FILE: src/tree_ancestor_binary_lifting_core.sv
// Binary-lifting lowest common ancestor engine: sequencer, jump table and depth memory.
// Depends on tal_pkg.
//
// Usage. Items arrive on the s_ channel: s_tuser carries the opcode (load,
// build, query), s_tdata the two node numbers. Every item gives exactly one
// result item on the m_ channel: m_tuser carries the status, m_tdata the
// ancestor (zero unless the status is a query answer). The cfg_ channel
// writes the node count; it is taken only while the engine is idle.
// The engine works on one item at a time with a single sequencer that walks
// the jump table through one write port and two registered read ports.
// A load, a rejected item or an unknown opcode goes from accept through the
// dispatch state straight to the result. A query first lifts the deeper node
// by the set bits of the depth difference; if it lands on the other node that
// is the answer, otherwise both climb the table together from the top level.
// In a build one pass fills each table level, then the depth walk visits
// each level for every node in use.
// Reset sets the node count to one and marks the tables as not built; the
// table contents are undefined until loaded and built. A finished result
// waits in the output register while the receiver stalls; the next item may
// be accepted meanwhile but its result waits for the register to free.
module tree_ancestor_binary_lifting_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [tal_pkg::S_TDATA_W-1:0]    s_tdata,   // first_node, second_node, zero pad
    input  logic [tal_pkg::OP_W-1:0]         s_tuser,   // opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tal_pkg::M_TDATA_W-1:0]    m_tdata,   // ancestor, zero pad
    output logic [tal_pkg::STAT_W-1:0]       m_tuser,   // status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tal_pkg::CNT_W-1:0]        cfg_data
);

    localparam int NODE_W  = tal_pkg::NODE_W;
    localparam int CNT_W   = tal_pkg::CNT_W;
    localparam int DEPTH_W = tal_pkg::DEPTH_W;
    localparam int DPT_W   = tal_pkg::DPT_W;
    localparam int LEVEL_W = tal_pkg::LEVEL_W;
    localparam int LVLC_W  = tal_pkg::LVLC_W;
    localparam int JT_AW   = tal_pkg::JT_AW;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISPATCH = 5'd1;
    localparam logic [4:0] S_SAN_RD   = 5'd2;
    localparam logic [4:0] S_SAN_WR   = 5'd3;
    localparam logic [4:0] S_LVL_RD1  = 5'd4;
    localparam logic [4:0] S_LVL_RD2  = 5'd5;
    localparam logic [4:0] S_LVL_WR   = 5'd6;
    localparam logic [4:0] S_DEP_INIT = 5'd7;
    localparam logic [4:0] S_DEP_RD   = 5'd8;
    localparam logic [4:0] S_DEP_UP   = 5'd9;
    localparam logic [4:0] S_DEP_WR   = 5'd10;
    localparam logic [4:0] S_Q_RDU    = 5'd11;
    localparam logic [4:0] S_Q_RDV    = 5'd12;
    localparam logic [4:0] S_Q_SWAP   = 5'd13;
    localparam logic [4:0] S_LIFT_RD  = 5'd14;
    localparam logic [4:0] S_LIFT_UP  = 5'd15;
    localparam logic [4:0] S_CMP      = 5'd16;
    localparam logic [4:0] S_TOP_RD   = 5'd17;
    localparam logic [4:0] S_TOP_UP   = 5'd18;
    localparam logic [4:0] S_FIN_RD   = 5'd19;
    localparam logic [4:0] S_FIN_UP   = 5'd20;
    localparam logic [4:0] S_DONE     = 5'd21;

    logic [4:0]                 state_reg, state_next;
    logic [tal_pkg::OP_W-1:0]   op_reg, op_next;
    logic [NODE_W-1:0]          a_reg, a_next;
    logic [NODE_W-1:0]          b_reg, b_next;
    logic [CNT_W-1:0]           node_count_reg, node_count_next;
    logic                       built_reg, built_next;
    logic [LVLC_W-1:0]          lvl_reg, lvl_next;
    logic [CNT_W-1:0]           j_reg, j_next;
    logic [NODE_W-1:0]          u_reg, u_next;
    logic [NODE_W-1:0]          v_reg, v_next;
    logic [DPT_W-1:0]           dpt_reg, dpt_next;
    logic [DEPTH_W-1:0]         diff_reg, diff_next;
    logic [NODE_W-1:0]          res_anc_reg, res_anc_next;
    logic [tal_pkg::STAT_W-1:0] res_st_reg, res_st_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [NODE_W-1:0]          m_anc_reg, m_anc_next;
    logic [tal_pkg::STAT_W-1:0] m_st_reg, m_st_next;

    // Memories and their ports
    logic [NODE_W-1:0]  jt_mem [tal_pkg::JT_DEPTH];
    logic [DEPTH_W-1:0] dp_mem [tal_pkg::MAX_NODES];
    logic [JT_AW-1:0]   jt_ra, jt_rb, jt_wa;
    logic               jt_we;
    logic [NODE_W-1:0]  jt_wd;
    logic [NODE_W-1:0]  jt_rd_a, jt_rd_b;
    logic [NODE_W-1:0]  dp_ra, dp_wa;
    logic               dp_we;
    logic [DEPTH_W-1:0] dp_wd;
    logic [DEPTH_W-1:0] dp_rd;

    logic [CNT_W-1:0]   cnt;
    logic [LVLC_W-1:0]  lvl_m1;
    logic [LEVEL_W-1:0] lvl_lo;
    logic [LEVEL_W-1:0] lvl_m1_lo;
    logic [NODE_W-1:0]  j_node;
    logic [DPT_W-1:0]   dsum;
    logic [DEPTH_W-1:0] dsat;
    logic               a_ok, b_ok;

    assign cnt       = (node_count_reg > tal_pkg::MAX_COUNT) ? tal_pkg::MAX_COUNT
                                                              : node_count_reg;
    assign lvl_m1    = lvl_reg - 1'b1;
    assign lvl_lo    = lvl_reg[LEVEL_W-1:0];
    assign lvl_m1_lo = lvl_m1[LEVEL_W-1:0];
    assign j_node    = j_reg[NODE_W-1:0];
    assign dsum      = dpt_reg + DPT_W'(u_reg != '0);
    assign dsat      = (dsum > DPT_W'(tal_pkg::DEPTH_MAX)) ? tal_pkg::DEPTH_MAX
                                                            : dsum[DEPTH_W-1:0];
    assign a_ok      = {1'b0, a_reg} < cnt;
    assign b_ok      = {1'b0, b_reg} < cnt;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = M_TDATA_W_EXT(m_anc_reg);
    assign m_tuser   = m_st_reg;

    function automatic logic [tal_pkg::M_TDATA_W-1:0] M_TDATA_W_EXT(
        input logic [NODE_W-1:0] anc);
        M_TDATA_W_EXT = tal_pkg::M_TDATA_W'(anc);
    endfunction

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        node_count_next = node_count_reg;
        built_next      = built_reg;
        lvl_next        = lvl_reg;
        j_next          = j_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        dpt_next        = dpt_reg;
        diff_next       = diff_reg;
        res_anc_next    = res_anc_reg;
        res_st_next     = res_st_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_anc_next      = m_anc_reg;
        m_st_next       = m_st_reg;

        jt_ra = '0;
        jt_rb = '0;
        jt_we = 1'b0;
        jt_wa = '0;
        jt_wd = '0;
        dp_ra = '0;
        dp_we = 1'b0;
        dp_wa = j_node;
        dp_wd = dsat;

        if (cfg_valid && cfg_ready)
        begin
            node_count_next = cfg_data;
            built_next      = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    a_next     = s_tdata[NODE_W-1:0];
                    b_next     = s_tdata[2*NODE_W-1:NODE_W];
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                res_anc_next = '0;
                res_st_next  = tal_pkg::STAT_REJECT;
                state_next   = S_DONE;
                unique case (op_reg)
                    tal_pkg::OP_LOAD:
                    begin
                        if (a_ok && b_ok)
                        begin
                            // The root stays its own parent.
                            jt_we       = (a_reg != '0);
                            jt_wa       = tal_pkg::jt_addr('0, a_reg);
                            jt_wd       = b_reg;
                            built_next  = 1'b0;
                            res_st_next = tal_pkg::STAT_OK;
                        end
                    end
                    tal_pkg::OP_BUILD:
                    begin
                        if (cnt == '0)
                        begin
                            built_next  = 1'b1;
                            res_st_next = tal_pkg::STAT_OK;
                        end
                        else
                        begin
                            jt_we      = 1'b1;
                            jt_wa      = tal_pkg::jt_addr('0, '0);
                            jt_wd      = '0;
                            j_next     = CNT_W'(1);
                            state_next = S_SAN_RD;
                        end
                    end
                    tal_pkg::OP_QUERY:
                    begin
                        if (built_reg && a_ok && b_ok)
                            state_next = S_Q_RDU;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SAN_RD:
            begin
                if (j_reg >= cnt)
                begin
                    lvl_next   = LVLC_W'(1);
                    j_next     = '0;
                    state_next = S_LVL_RD1;
                end
                else
                begin
                    jt_ra      = tal_pkg::jt_addr('0, j_node);
                    state_next = S_SAN_WR;
                end
            end
            S_SAN_WR:
            begin
                // A stale parent outside the live range falls back to the root.
                jt_we      = ({1'b0, jt_rd_a} >= cnt);
                jt_wa      = tal_pkg::jt_addr('0, j_node);
                jt_wd      = '0;
                j_next     = j_reg + 1'b1;
                state_next = S_SAN_RD;
            end
            S_LVL_RD1:
            begin
                if (lvl_reg >= tal_pkg::LEVEL_TOP)
                begin
                    j_next     = '0;
                    state_next = S_DEP_INIT;
                end
                else if (j_reg >= cnt)
                begin
                    lvl_next = lvl_reg + 1'b1;
                    j_next   = '0;
                end
                else
                begin
                    jt_ra      = tal_pkg::jt_addr(lvl_m1_lo, j_node);
                    state_next = S_LVL_RD2;
                end
            end
            S_LVL_RD2:
            begin
                jt_ra      = tal_pkg::jt_addr(lvl_m1_lo, jt_rd_a);
                state_next = S_LVL_WR;
            end
            S_LVL_WR:
            begin
                jt_we      = 1'b1;
                jt_wa      = tal_pkg::jt_addr(lvl_lo, j_node);
                jt_wd      = jt_rd_a;
                j_next     = j_reg + 1'b1;
                state_next = S_LVL_RD1;
            end
            S_DEP_INIT:
            begin
                if (j_reg >= cnt)
                begin
                    built_next   = 1'b1;
                    res_anc_next = '0;
                    res_st_next  = tal_pkg::STAT_OK;
                    state_next   = S_DONE;
                end
                else
                begin
                    u_next     = j_node;
                    dpt_next   = '0;
                    lvl_next   = tal_pkg::LEVEL_TOP;
                    state_next = S_DEP_RD;
                end
            end
            S_DEP_RD:
            begin
                if (lvl_reg == '0)
                    state_next = S_DEP_WR;
                else
                begin
                    jt_ra      = tal_pkg::jt_addr(lvl_m1_lo, u_reg);
                    state_next = S_DEP_UP;
                end
            end
            S_DEP_UP:
            begin
                if (jt_rd_a != '0)
                begin
                    u_next   = jt_rd_a;
                    dpt_next = dpt_reg + (DPT_W'(1) << lvl_m1);
                end
                lvl_next   = lvl_m1;
                state_next = S_DEP_RD;
            end
            S_DEP_WR:
            begin
                dp_we      = 1'b1;
                j_next     = j_reg + 1'b1;
                state_next = S_DEP_INIT;
            end
            S_Q_RDU:
            begin
                dp_ra      = a_reg;
                state_next = S_Q_RDV;
            end
            S_Q_RDV:
            begin
                diff_next  = dp_rd;
                dp_ra      = b_reg;
                state_next = S_Q_SWAP;
            end
            S_Q_SWAP:
            begin
                // diff_reg holds the depth of the first node at this point.
                if (diff_reg < dp_rd)
                begin
                    u_next    = b_reg;
                    v_next    = a_reg;
                    diff_next = dp_rd - diff_reg;
                end
                else
                begin
                    u_next    = a_reg;
                    v_next    = b_reg;
                    diff_next = diff_reg - dp_rd;
                end
                lvl_next   = '0;
                state_next = S_LIFT_RD;
            end
            S_LIFT_RD:
            begin
                if (lvl_reg >= tal_pkg::LEVEL_TOP)
                    state_next = S_CMP;
                else if (diff_reg[0])
                begin
                    jt_ra      = tal_pkg::jt_addr(lvl_lo, u_reg);
                    state_next = S_LIFT_UP;
                end
                else
                begin
                    diff_next = diff_reg >> 1;
                    lvl_next  = lvl_reg + 1'b1;
                end
            end
            S_LIFT_UP:
            begin
                u_next     = jt_rd_a;
                diff_next  = diff_reg >> 1;
                lvl_next   = lvl_reg + 1'b1;
                state_next = S_LIFT_RD;
            end
            S_CMP:
            begin
                if (u_reg == v_reg)
                begin
                    res_anc_next = u_reg;
                    res_st_next  = tal_pkg::STAT_ANSWER;
                    state_next   = S_DONE;
                end
                else
                begin
                    lvl_next   = tal_pkg::LEVEL_TOP;
                    state_next = S_TOP_RD;
                end
            end
            S_TOP_RD:
            begin
                if (lvl_reg == '0)
                    state_next = S_FIN_RD;
                else
                begin
                    jt_ra      = tal_pkg::jt_addr(lvl_m1_lo, u_reg);
                    jt_rb      = tal_pkg::jt_addr(lvl_m1_lo, v_reg);
                    state_next = S_TOP_UP;
                end
            end
            S_TOP_UP:
            begin
                if (jt_rd_a != jt_rd_b)
                begin
                    u_next = jt_rd_a;
                    v_next = jt_rd_b;
                end
                lvl_next   = lvl_m1;
                state_next = S_TOP_RD;
            end
            S_FIN_RD:
            begin
                jt_ra      = tal_pkg::jt_addr('0, v_reg);
                state_next = S_FIN_UP;
            end
            S_FIN_UP:
            begin
                res_anc_next = jt_rd_a;
                res_st_next  = tal_pkg::STAT_ANSWER;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_anc_next    = res_anc_reg;
                    m_st_next     = res_st_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= tal_pkg::COUNT_RST;
            built_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            built_reg      <= built_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        lvl_reg     <= lvl_next;
        j_reg       <= j_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        dpt_reg     <= dpt_next;
        diff_reg    <= diff_next;
        res_anc_reg <= res_anc_next;
        res_st_reg  <= res_st_next;
        m_anc_reg   <= m_anc_next;
        m_st_reg    <= m_st_next;
    end

    always_ff @(posedge clk)
    begin
        if (jt_we)
            jt_mem[jt_wa] <= jt_wd;
        jt_rd_a <= jt_mem[jt_ra];
        jt_rd_b <= jt_mem[jt_rb];
    end

    always_ff @(posedge clk)
    begin
        if (dp_we)
            dp_mem[dp_wa] <= dp_wd;
        dp_rd <= dp_mem[dp_ra];
    end

endmodule

FILE: src/tal_checker.sv
// Port-level checker for tree_ancestor_binary_lifting_core, bound into that module.
// Depends on tal_pkg.
module tal_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [tal_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [tal_pkg::STAT_W-1:0]    m_tuser,
    input  logic                          cfg_ready
);

    // A stalled result holds still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == tal_pkg::STAT_OK || m_tuser == tal_pkg::STAT_ANSWER
                      || m_tuser == tal_pkg::STAT_REJECT))
        else $error("result carries an unknown status");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != tal_pkg::STAT_ANSWER |-> m_tdata == '0)
        else $error("non-answer result carries a nonzero ancestor");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready && !cfg_ready)
        else $error("engine took new work straight after accepting an item");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> s_tready)
        else $error("configuration port open while engine busy");

endmodule

bind tree_ancestor_binary_lifting_core tal_checker u_tal_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_ready (cfg_ready)
);
